/* sv/pdgr_pkg.sv */
package pdgr_pkg;

  localparam int MAX_SEGMENTS = 32;

  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_QUERY = 2'd1;
  localparam logic [1:0] CMD_CLEAR = 2'd2;

  localparam logic [2:0] ST_OK     = 3'd0;
  localparam logic [2:0] ST_NOSEG  = 3'd1;
  localparam logic [2:0] ST_NODOM  = 3'd2;
  localparam logic [2:0] ST_BEYOND = 3'd3;
  localparam logic [2:0] ST_OVF    = 3'd4;

  // x / 3 == (x * RECIP3) >> 33 for every 32-bit x
  localparam logic [31:0] RECIP3 = 32'hAAAA_AAAB;

  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] genomic_lo;
    logic [31:0] genomic_hi;
    logic [4:0]  segment_index;
    logic [31:0] nt_lo;
    logic [31:0] nt_hi;
    logic [30:0] aa_lo;
    logic [30:0] aa_hi;
    logic [30:0] protein_len_aa;
    logic        unclamped;
    logic        last;
  } res_t;

  typedef struct packed {
    logic cap;
    logic clr;
    logic ld_diff;
    logic ld_commit;
    logic q_calc;
    logic q_dec;
    logic walk;
    logic push_final;
  } dp_ctl_t;

  typedef struct packed {
    logic q_bad;
    logic walk_done;
    logic o_free;
  } dp_stat_t;

endpackage

/* sv/pdgr_ctrl.sv */
module pdgr_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         cmd,
  input  pdgr_pkg::dp_stat_t st,
  output pdgr_pkg::dp_ctl_t  ctl
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_LOAD1 = 8'b0000_0010,
    S_LOAD2 = 8'b0000_0100,
    S_QCALC = 8'b0000_1000,
    S_QDEC  = 8'b0001_0000,
    S_STAT  = 8'b0010_0000,
    S_WALK  = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    in_ready   = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.cap = 1'b1;
          unique case (cmd)
            pdgr_pkg::CMD_LOAD:  state_next = S_LOAD1;
            pdgr_pkg::CMD_QUERY: state_next = S_QCALC;
            pdgr_pkg::CMD_CLEAR: ctl.clr = 1'b1;
            default:             state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD1: begin
        ctl.ld_diff = 1'b1;
        state_next  = S_LOAD2;
      end
      S_LOAD2: begin
        ctl.ld_commit = 1'b1;
        state_next    = S_IDLE;
      end
      S_QCALC: begin
        ctl.q_calc = 1'b1;
        state_next = S_QDEC;
      end
      S_QDEC: begin
        ctl.q_dec  = 1'b1;
        state_next = st.q_bad ? S_STAT : S_WALK;
      end
      S_STAT: begin
        if (st.o_free) begin
          ctl.push_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      S_WALK: begin
        ctl.walk = 1'b1;
        if (st.walk_done) begin
          state_next = S_FIN;
        end
      end
      S_FIN: begin
        if (st.o_free) begin
          ctl.push_final = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

/* sv/pdgr_dp.sv */
module pdgr_dp #(
  parameter int MAX_SEGMENTS = pdgr_pkg::MAX_SEGMENTS
) (
  input  logic               clk,
  input  logic               rst,
  input  pdgr_pkg::dp_ctl_t  ctl,
  output pdgr_pkg::dp_stat_t st,
  input  logic [31:0]        seg_start,
  input  logic [31:0]        seg_end,
  input  logic               seg_minus,
  input  logic [23:0]        dom_first_aa,
  input  logic [23:0]        dom_last_aa,
  output pdgr_pkg::res_t     o_res,
  output logic               o_valid,
  input  logic               out_ready
);

  localparam int IDX_W = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEGMENTS);

  typedef struct packed {
    logic [31:0] lo;
    logic [31:0] hi;
    logic        minus;
    logic [31:0] cs;
    logic [31:0] ce;
  } ent_t;

  ent_t mem [MAX_SEGMENTS];

  // table bookkeeping
  logic [CNT_W-1:0] seg_count;
  logic [31:0]      coding_len;
  logic             overflow_flag;

  // captured input word
  logic [31:0] ld_lo, ld_hi;
  logic        ld_minus;
  logic [23:0] q_first, q_last;
  logic [31:0] ld_diff;
  logic        ld_drop;

  always_ff @(posedge clk) begin
    if (ctl.cap) begin
      ld_lo    <= seg_start;
      ld_hi    <= seg_end;
      ld_minus <= seg_minus;
      q_first  <= dom_first_aa;
      q_last   <= dom_last_aa;
    end
    if (ctl.ld_diff) begin
      ld_diff <= ld_hi - ld_lo;
      ld_drop <= ld_hi < ld_lo;
    end
  end

  logic [32:0] nt_sum;
  logic        tbl_full;
  logic        ld_ok;

  assign nt_sum   = {1'b0, coding_len} + {1'b0, ld_diff} + 33'd1;
  assign tbl_full = seg_count >= CNT_MAX;
  assign ld_ok    = ctl.ld_commit && !ld_drop && !tbl_full && !nt_sum[32];

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_count     <= '0;
      coding_len    <= '0;
      overflow_flag <= 1'b0;
    end else if (ctl.clr) begin
      seg_count     <= '0;
      coding_len    <= '0;
      overflow_flag <= 1'b0;
    end else if (ctl.ld_commit && !ld_drop) begin
      if (tbl_full || nt_sum[32]) begin
        overflow_flag <= 1'b1;
      end else begin
        seg_count  <= seg_count + CNT_W'(1);
        coding_len <= nt_sum[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld_ok) begin
      mem[seg_count[IDX_W-1:0]] <= '{lo: ld_lo, hi: ld_hi, minus: ld_minus,
                                     cs: coding_len, ce: coding_len + ld_diff};
    end
  end

  // query setup
  logic [31:0] f_m1, l_ext;
  logic [31:0] ds, de;
  logic [63:0] plen_prod;
  logic [30:0] plen;
  logic [2:0]  st_reg;
  logic        full_r;
  logic [2:0]  q_code;
  logic        beyond_de, beyond_ds;

  assign f_m1  = {8'd0, q_first} - 32'd1;
  assign l_ext = {8'd0, q_last};
  assign plen  = plen_prod[63:33];

  assign beyond_de = de >= coding_len;
  assign beyond_ds = ds >= coding_len;

  always_comb begin
    priority if (overflow_flag)                     q_code = pdgr_pkg::ST_OVF;
    else if (seg_count == '0)                       q_code = pdgr_pkg::ST_NOSEG;
    else if (q_first == '0 || q_last < q_first)     q_code = pdgr_pkg::ST_NODOM;
    else if (beyond_de && beyond_ds)                q_code = pdgr_pkg::ST_BEYOND;
    else                                            q_code = pdgr_pkg::ST_OK;
  end

  assign st.q_bad = q_code != pdgr_pkg::ST_OK;

  always_ff @(posedge clk) begin
    if (ctl.q_calc) begin
      ds        <= f_m1 + {f_m1[30:0], 1'b0};
      de        <= l_ext + {l_ext[30:0], 1'b0} - 32'd1;
      plen_prod <= 64'(coding_len) * 64'(pdgr_pkg::RECIP3);
    end else if (ctl.q_dec) begin
      // a walk that finds no overlap reports beyond protein
      st_reg <= st.q_bad ? q_code : pdgr_pkg::ST_BEYOND;
      full_r <= !beyond_de;
      if (beyond_de) begin
        de <= coding_len - 32'd1;
      end
    end
  end

  // walk pipeline: read, overlap, offsets and divide, finish
  logic             en, issue;
  logic [CNT_W-1:0] idx;
  logic             v1, v2, v3;
  ent_t             rd;
  logic [IDX_W-1:0] idx1, idx2, idx3;

  logic             hit1;
  logic [31:0]      os1, oe1;

  logic             hit2, minus2;
  logic [31:0]      lo2, hi2, cs2, os2, oe2;

  logic             hit3, minus3;
  logic [31:0]      lo3, hi3, os3, oe3, offs3, offe3;
  logic [63:0]      mos3, moe3;

  pdgr_pkg::res_t   s3_res, p_res, fin_res;
  logic             p_valid;

  assign issue = ctl.walk && en && (idx < seg_count);
  assign st.walk_done = (idx == seg_count) && !v1 && !v2 && !v3;
  assign st.o_free    = !o_valid || out_ready;
  // freeze the walk while a new overlap would find both holding registers full
  assign en = !(v3 && hit3 && p_valid && o_valid && !out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= issue;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.q_dec) begin
      idx <= '0;
    end else if (issue) begin
      idx <= idx + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd   <= mem[idx[IDX_W-1:0]];
      idx1 <= idx[IDX_W-1:0];
    end
  end

  assign hit1 = (ds <= rd.ce) && (rd.cs <= de);
  assign os1  = (ds > rd.cs) ? ds : rd.cs;
  assign oe1  = (de < rd.ce) ? de : rd.ce;

  always_ff @(posedge clk) begin
    if (en) begin
      hit2   <= hit1;
      idx2   <= idx1;
      lo2    <= rd.lo;
      hi2    <= rd.hi;
      minus2 <= rd.minus;
      cs2    <= rd.cs;
      os2    <= os1;
      oe2    <= oe1;

      hit3   <= hit2;
      idx3   <= idx2;
      lo3    <= lo2;
      hi3    <= hi2;
      minus3 <= minus2;
      os3    <= os2;
      oe3    <= oe2;
      offs3  <= os2 - cs2;
      offe3  <= oe2 - cs2;
      mos3   <= 64'(os2) * 64'(pdgr_pkg::RECIP3);
      moe3   <= 64'(oe2) * 64'(pdgr_pkg::RECIP3);
    end
  end

  always_comb begin
    s3_res.status = pdgr_pkg::ST_OK;
    if (minus3) begin
      s3_res.genomic_lo = hi3 - offe3;
      s3_res.genomic_hi = hi3 - offs3;
    end else begin
      s3_res.genomic_lo = lo3 + offs3;
      s3_res.genomic_hi = lo3 + offe3;
    end
    s3_res.segment_index  = 5'(idx3);
    s3_res.nt_lo          = os3;
    s3_res.nt_hi          = oe3;
    s3_res.aa_lo          = mos3[63:33] + 31'd1;
    s3_res.aa_hi          = moe3[63:33] + 31'd1;
    s3_res.protein_len_aa = plen;
    s3_res.unclamped      = full_r;
    s3_res.last           = 1'b0;
  end

  always_comb begin
    if (p_valid) begin
      fin_res      = p_res;
      fin_res.last = 1'b1;
    end else begin
      fin_res        = '0;
      fin_res.status = st_reg;
      fin_res.last   = 1'b1;
      if (st_reg != pdgr_pkg::ST_NOSEG && st_reg != pdgr_pkg::ST_OVF) begin
        fin_res.protein_len_aa = plen;
      end
    end
  end

  // pending word: its last flag is known only once the next overlap or the walk end shows up
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (ctl.q_dec) begin
      p_valid <= 1'b0;
    end else if (en && v3 && hit3) begin
      p_valid <= 1'b1;
    end else if (ctl.push_final) begin
      p_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en && v3 && hit3) begin
      p_res <= s3_res;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      o_valid <= 1'b0;
    end else if (ctl.push_final || (en && v3 && hit3 && p_valid)) begin
      o_valid <= 1'b1;
    end else if (out_ready) begin
      o_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push_final) begin
      o_res <= fin_res;
    end else if (en && v3 && hit3 && p_valid) begin
      o_res <= p_res;
    end
  end

endmodule

/* sv/protein_domain_to_genomic_ranges.sv */
// channel  direction  handshake              payload
// in       input      in_valid / in_ready    cmd, seg_start, seg_end, seg_minus,
//                                            dom_first_aa, dom_last_aa
// out      output     out_valid / out_ready  status, genomic_lo, genomic_hi,
//                                            segment_index, nt_lo, nt_hi, aa_lo,
//                                            aa_hi, protein_len_aa, unclamped, last
//
// a mapping query streams the stored segments through a 4-stage datapath at one segment
// a cycle, bound by the single read port of the segment table. in_ready is high only
// between words; one output register and one pending register hold results, and a
// stalled output freezes the segment walk. reset clears the segment count, coding
// length and overflow flag; table contents are left as they are and never read before
// being written.
module protein_domain_to_genomic_ranges #(
  parameter int MAX_SEGMENTS = pdgr_pkg::MAX_SEGMENTS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  cmd,
  input  logic [31:0] seg_start,
  input  logic [31:0] seg_end,
  input  logic        seg_minus,
  input  logic [23:0] dom_first_aa,
  input  logic [23:0] dom_last_aa,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  status,
  output logic [31:0] genomic_lo,
  output logic [31:0] genomic_hi,
  output logic [4:0]  segment_index,
  output logic [31:0] nt_lo,
  output logic [31:0] nt_hi,
  output logic [30:0] aa_lo,
  output logic [30:0] aa_hi,
  output logic [30:0] protein_len_aa,
  output logic        unclamped,
  output logic        last
);

  pdgr_pkg::dp_ctl_t  ctl;
  pdgr_pkg::dp_stat_t st;
  pdgr_pkg::res_t     o_res;

  pdgr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .st       (st),
    .ctl      (ctl)
  );

  pdgr_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctl          (ctl),
    .st           (st),
    .seg_start    (seg_start),
    .seg_end      (seg_end),
    .seg_minus    (seg_minus),
    .dom_first_aa (dom_first_aa),
    .dom_last_aa  (dom_last_aa),
    .o_res        (o_res),
    .o_valid      (out_valid),
    .out_ready    (out_ready)
  );

  assign status         = o_res.status;
  assign genomic_lo     = o_res.genomic_lo;
  assign genomic_hi     = o_res.genomic_hi;
  assign segment_index  = o_res.segment_index;
  assign nt_lo          = o_res.nt_lo;
  assign nt_hi          = o_res.nt_hi;
  assign aa_lo          = o_res.aa_lo;
  assign aa_hi          = o_res.aa_hi;
  assign protein_len_aa = o_res.protein_len_aa;
  assign unclamped      = o_res.unclamped;
  assign last           = o_res.last;

endmodule
